// ===== design/gmc_pkg.sv =====
// Shared types, codes and arithmetic helpers for the minimum cut engine.
`default_nettype none
package gmc_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_WEIGHT_BITS  = 16;
	localparam int CUT_BITS         = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// per-cycle orders from the sequencer to every cell
	typedef struct packed {
		logic start;  // load active flag from vertex count
		logic init;   // new phase: clear added flag and attachment
		logic shift;  // row word moves one cell along
		logic apply;  // add held row word to attachment
		logic mark;   // flag the addressed cell as added
		logic kill;   // drop the addressed cell from the graph
	} cell_ctl_t;

	function automatic logic [CUT_BITS-1:0] sat_add(input logic [CUT_BITS-1:0] a,
		input logic [CUT_BITS-1:0] b);
		logic [CUT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CUT_BITS] ? {CUT_BITS{1'b1}} : s[CUT_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/gmc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module gmc_ram #(
	parameter int W = 32,
	parameter int D = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/gmc_cell.sv =====
// One vertex cell: flags, attachment weight, row shift stage, argmax token stage.
`default_nettype none
module gmc_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int CW  = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gmc_pkg::cell_ctl_t            ctl,
	input  wire logic [IW-1:0]                 sel_idx,
	input  wire logic [CW-1:0]                 n,
	input  wire logic [gmc_pkg::CUT_BITS-1:0]  row_in,
	output logic      [gmc_pkg::CUT_BITS-1:0]  row_out,
	input  wire logic                          tf_in,
	input  wire logic [gmc_pkg::CUT_BITS-1:0]  tt_in,
	input  wire logic [IW-1:0]                 ti_in,
	output logic                               tf_out,
	output logic      [gmc_pkg::CUT_BITS-1:0]  tt_out,
	output logic      [IW-1:0]                 ti_out
);
	logic                         act_q, added_q;
	logic [gmc_pkg::CUT_BITS-1:0] att_q, row_q;
	logic                         tf_q;
	logic [gmc_pkg::CUT_BITS-1:0] tt_q;
	logic [IW-1:0]                ti_q;
	logic                         hit, take;

	assign hit  = (sel_idx == IW'(IDX));
	// strict compare keeps the lowest index on ties
	assign take = act_q && !added_q && (!tf_in || (att_q > tt_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			added_q <= 1'b0;
			tf_q    <= 1'b0;
		end else begin
			tf_q <= tf_in || take;
			if (ctl.start) begin
				act_q <= (CW'(IDX) < n);
			end else if (ctl.kill && hit) begin
				act_q <= 1'b0;
			end
			if (ctl.init) begin
				added_q <= 1'b0;
			end else if (ctl.mark && hit) begin
				added_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tt_q <= take ? att_q : tt_in;
		ti_q <= take ? IW'(IDX) : ti_in;
		if (ctl.shift) begin
			row_q <= row_in;
		end
		if (ctl.init) begin
			att_q <= '0;
		end else if (ctl.apply && act_q && !added_q) begin
			att_q <= gmc_pkg::sat_add(att_q, row_q);
		end
	end

	assign row_out = row_q;
	assign tf_out  = tf_q;
	assign tt_out  = tt_q;
	assign ti_out  = ti_q;
endmodule
`default_nettype wire

// ===== design/global_min_cut_dense.sv =====
// Top level of the dense-store global minimum cut engine (Stoer-Wagner).
// Items are commands: clear zeroes the weight store, write sets one edge both ways,
// run returns one min_cut item. The weight store (2^(2*IW) words, IW = clog2 of
// MAX_VERTICES) is swept clear after reset and on every clear item, one word a cycle,
// during which no item is taken (configuration still is). An edge write stores (a,b)
// as it is taken and (b,a) in S_WR2. A run copies the store into a working RAM, then
// for each of the n-1 phases clears the cells (S_PINIT) and walks a row of vertex
// cells: each vertex selection waits in S_SEL for the argmax token to cross the chain,
// each non-final vertex streams its row (S_ROW) and adds it (S_APPLY), and the merge
// reads and writes the working RAM column by column (S_MRD1, S_MRD2, S_MWR1, S_MWR2).
// A run with fewer than two vertices answers 0 with no copy. The result waits in an
// output register, so the next item is taken while it is still unread.
`default_nettype none
module global_min_cut_dense #(
	parameter int MAX_VERTICES = gmc_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = gmc_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  vertex_count,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  node_a,
	input  wire logic [5:0]  node_b,
	input  wire logic [15:0] edge_weight,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      min_cut
);
	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int AW   = 2 * IW;
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int CTRW = AW + 1;
	localparam int CB   = gmc_pkg::CUT_BITS;

	typedef enum logic [12:0] {
		S_CLR   = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_WR2   = 13'b0000000000100,
		S_COPY  = 13'b0000000001000,
		S_PINIT = 13'b0000000010000,
		S_SEL   = 13'b0000000100000,
		S_ROW   = 13'b0000001000000,
		S_APPLY = 13'b0000010000000,
		S_MRD1  = 13'b0000100000000,
		S_MRD2  = 13'b0001000000000,
		S_MWR1  = 13'b0010000000000,
		S_MWR2  = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t                 state_q;
	logic [CTRW-1:0]        ctr_q;
	logic [6:0]             vc_q;
	logic [CW-1:0]          cnt_q, added_q;
	logic [IW-1:0]          sel_q, prev_q, keep_q, gone_q;
	logic [IW-1:0]          wa_q, wb_q;
	logic [WEIGHT_BITS-1:0] ww_q;
	logic [CB-1:0]          best_q, tmp_q, mw_q;
	logic                   ov_q;
	logic [CB-1:0]          min_cut_q;
	logic                   cp_v_s1, rv_s1;
	logic [AW-1:0]          cp_addr_s1;

	// weight store ports
	logic                   w_we;
	logic [AW-1:0]          w_waddr, w_raddr;
	logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
	// working store ports
	logic                   k_we;
	logic [AW-1:0]          k_waddr, k_raddr;
	logic [CB-1:0]          k_wdata, k_rdata;

	gmc_pkg::cell_ctl_t ctl;
	logic [CW-1:0]      n_clamp;
	logic [IW-1:0]      cell_idx;
	logic               acc, a_ok;
	logic [IW-1:0]      a_i, b_i;
	logic [IW-1:0]      col;
	logic [CB-1:0]      msum;

	// cell chain links
	logic          tf [MAX_VERTICES+1];
	logic [CB-1:0] tt [MAX_VERTICES+1];
	logic [IW-1:0] ti [MAX_VERTICES+1];
	logic [CB-1:0] rw [MAX_VERTICES+1];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = ov_q;
	assign min_cut   = min_cut_q;

	assign n_clamp = ({2'b0, vc_q} > 9'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_q);
	assign a_ok    = ({3'b0, node_a} < 9'(MAX_VERTICES)) && ({3'b0, node_b} < 9'(MAX_VERTICES));
	assign a_i     = IW'(node_a);
	assign b_i     = IW'(node_b);
	// row words go in from the far column so that word j settles in cell j
	assign col     = IW'(MAX_VERTICES - 1) - ctr_q[IW-1:0];
	assign msum    = gmc_pkg::sat_add(tmp_q, k_rdata);

	gmc_ram #(.W(WEIGHT_BITS), .D(1 << AW)) u_wstore (
		.clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
	);

	gmc_ram #(.W(CB), .D(1 << AW)) u_kstore (
		.clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
	);

	assign tf[0] = 1'b0;
	assign tt[0] = '0;
	assign ti[0] = '0;
	assign rw[0] = k_rdata;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		gmc_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
			.clk, .arst_n, .ctl, .sel_idx(cell_idx), .n(n_clamp),
			.row_in(rw[g]), .row_out(rw[g+1]),
			.tf_in(tf[g]), .tt_in(tt[g]), .ti_in(ti[g]),
			.tf_out(tf[g+1]), .tt_out(tt[g+1]), .ti_out(ti[g+1])
		);
	end

	// store port steering
	always_comb begin
		w_we    = 1'b0;
		w_waddr = ctr_q[AW-1:0];
		w_wdata = '0;
		w_raddr = ctr_q[AW-1:0];
		k_we    = 1'b0;
		k_waddr = cp_addr_s1;
		k_wdata = CB'(w_rdata);
		k_raddr = {sel_q, col};
		cell_idx = ti[MAX_VERTICES];
		unique case (state_q)
			S_CLR: begin
				w_we = 1'b1;
			end
			S_IDLE: begin
				w_we    = acc && (command == gmc_pkg::CMD_WRITE) && a_ok;
				w_waddr = {a_i, b_i};
				w_wdata = WEIGHT_BITS'(edge_weight);
			end
			S_WR2: begin
				w_we    = 1'b1;
				w_waddr = {wb_q, wa_q};
				w_wdata = ww_q;
			end
			S_MRD1: k_raddr = {keep_q, ctr_q[IW-1:0]};
			S_MRD2: k_raddr = {gone_q, ctr_q[IW-1:0]};
			S_MWR1: begin
				k_we    = 1'b1;
				k_waddr = {keep_q, ctr_q[IW-1:0]};
				k_wdata = msum;
			end
			S_MWR2: begin
				k_we     = 1'b1;
				k_waddr  = {ctr_q[IW-1:0], keep_q};
				k_wdata  = mw_q;
				cell_idx = gone_q;
			end
			default: ;
		endcase
		if (cp_v_s1) begin
			k_we = 1'b1;
		end
	end

	always_comb begin
		ctl       = '0;
		ctl.start = acc && (command == gmc_pkg::CMD_RUN);
		ctl.init  = (state_q == S_PINIT);
		ctl.shift = rv_s1;
		ctl.apply = (state_q == S_APPLY);
		ctl.mark  = (state_q == S_SEL) && (ctr_q == CTRW'(MAX_VERTICES));
		ctl.kill  = (state_q == S_MWR2) && (ctr_q == CTRW'(MAX_VERTICES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ctr_q   <= '0;
			vc_q    <= '0;
			ov_q    <= 1'b0;
			cp_v_s1 <= 1'b0;
			rv_s1   <= 1'b0;
			best_q  <= '1;
			cnt_q   <= '0;
			added_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vc_q <= vertex_count;
			end
			if (out_valid && out_ready) begin
				ov_q <= 1'b0;
			end
			cp_v_s1 <= (state_q == S_COPY) && !ctr_q[AW];
			rv_s1   <= (state_q == S_ROW) && (ctr_q < CTRW'(MAX_VERTICES));
			unique case (state_q)
				S_CLR: begin
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q[AW-1:0] == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						ctr_q <= '0;
						unique case (command)
							gmc_pkg::CMD_CLEAR: state_q <= S_CLR;
							gmc_pkg::CMD_WRITE: if (a_ok) state_q <= S_WR2;
							gmc_pkg::CMD_RUN: begin
								cnt_q <= n_clamp;
								if (n_clamp < CW'(2)) begin
									best_q  <= '0;
									state_q <= S_DONE;
								end else begin
									best_q  <= '1;
									state_q <= S_COPY;
								end
							end
							default: ;
						endcase
					end
				end
				S_WR2: state_q <= S_IDLE;
				S_COPY: begin
					if (!ctr_q[AW]) begin
						ctr_q <= ctr_q + 1'b1;
					end else begin
						state_q <= S_PINIT;
					end
				end
				S_PINIT: begin
					added_q <= '0;
					ctr_q   <= '0;
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (ctr_q == CTRW'(MAX_VERTICES)) begin
						added_q <= added_q + 1'b1;
						ctr_q   <= '0;
						if (added_q == cnt_q - 1'b1) begin
							if (tt[MAX_VERTICES] < best_q) begin
								best_q <= tt[MAX_VERTICES];
							end
							state_q <= S_MRD1;
						end else begin
							prev_q  <= ti[MAX_VERTICES];
							state_q <= S_ROW;
						end
					end else begin
						ctr_q <= ctr_q + 1'b1;
					end
				end
				S_ROW: begin
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == CTRW'(MAX_VERTICES)) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					ctr_q   <= '0;
					state_q <= S_SEL;
				end
				S_MRD1: state_q <= S_MRD2;
				S_MRD2: state_q <= S_MWR1;
				S_MWR1: state_q <= S_MWR2;
				S_MWR2: begin
					if (ctr_q == CTRW'(MAX_VERTICES - 1)) begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= (cnt_q == CW'(2)) ? S_DONE : S_PINIT;
					end else begin
						ctr_q   <= ctr_q + 1'b1;
						state_q <= S_MRD1;
					end
				end
				S_DONE: begin
					if (!ov_q) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= ctr_q[AW-1:0];
		if (acc) begin
			wa_q <= a_i;
			wb_q <= b_i;
			ww_q <= WEIGHT_BITS'(edge_weight);
		end
		if ((state_q == S_SEL) && (ctr_q == CTRW'(MAX_VERTICES))) begin
			sel_q  <= ti[MAX_VERTICES];
			keep_q <= prev_q;
			gone_q <= ti[MAX_VERTICES];
		end
		if (state_q == S_MRD2) begin
			tmp_q <= k_rdata;
		end
		if (state_q == S_MWR1) begin
			mw_q <= msum;
		end
		if ((state_q == S_DONE) && !ov_q) begin
			min_cut_q <= best_q;
		end
	end

	// a selection always finds a vertex still outside the ordering
	a_sel_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) && (ctr_q == CTRW'(MAX_VERTICES)) |-> tf[MAX_VERTICES])
		else $error("argmax token empty at selection");

	// phases only run on a graph of two vertices or more
	a_cnt_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PINIT) |-> (cnt_q >= CW'(2)))
		else $error("phase started with fewer than two vertices");

	// a run on fewer than two vertices answers zero
	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (command == gmc_pkg::CMD_RUN) && (n_clamp < CW'(2)) |=>
		(state_q == S_DONE) && (best_q == '0))
		else $error("small graph did not give zero");

	// a result only appears from the completion state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside completion");

	// the added count never passes the active count
	a_added_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) |-> (added_q < cnt_q))
		else $error("ordering overran active vertices");
endmodule
`default_nettype wire

// ===== test/global_min_cut_dense_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the dense-store global minimum cut engine: directed table, random graphs, then one full-size graph.
module global_min_cut_dense_tb;

	localparam int NV = gmc_pkg::DEF_MAX_VERTICES;
	// Longest quiet time after the last result: a clear sweep of the whole store.
	localparam int SETTLE = 4400;
	// The longest test holds one full 64 vertex cut plus the directed table and 45 random
	// graphs with clears, copies, settling and stalls; this limit allows several times that.
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int RAND_GRAPHS = 45;

	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [6:0]      vertex_count;
	logic            in_valid;
	logic            in_ready;
	gmc_pkg::cmd_t   command;
	logic [5:0]      node_a;
	logic [5:0]      node_b;
	logic [15:0]     edge_weight;
	logic            out_valid;
	logic            out_ready;
	logic [31:0]     min_cut;

	global_min_cut_dense u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.vertex_count (vertex_count),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.node_a       (node_a),
		.node_b       (node_b),
		.edge_weight  (edge_weight),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_cut      (min_cut)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: graph, scratch copy for merging, vertex count
	// ---------------------------------------------------------------
	logic [31:0] graph_w [NV][NV];
	logic [31:0] merged_w [NV][NV];
	logic [6:0]  nv_set;
	logic [31:0] cut_q [$];    // expected min_cut items, oldest first

	int     fails;
	longint cycles;
	bit     calm;              // when set, neither side idles
	logic [31:0] want;

	function automatic logic [31:0] add_clip(input logic [31:0] x, input logic [31:0] y);
		logic [32:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Stoer-Wagner on the predictor's copy; ties go to the lowest slot.
	function automatic logic [31:0] stoer_wagner_cut();
		int n, cnt, prev, sel, keep, gone, o;
		bit found;
		logic [31:0] top, best, w;
		int alive [NV];
		logic [31:0] attach [NV];
		bit taken [NV];
		n = (nv_set > NV) ? NV : nv_set;
		if (n < 2)
			return 32'd0;
		best = 32'hFFFF_FFFF;
		merged_w = graph_w;
		for (int i = 0; i < n; i++)
			alive[i] = i;
		cnt = n;
		while (cnt > 1) begin
			prev = 0;
			for (int j = 0; j < cnt; j++) begin
				attach[j] = 0;
				taken[j] = 0;
			end
			for (int i = 0; i < cnt; i++) begin
				sel = 0;
				top = 0;
				found = 0;
				for (int j = 0; j < cnt; j++) begin
					if (!taken[j] && (!found || attach[j] > top)) begin
						top = attach[j];
						sel = j;
						found = 1;
					end
				end
				taken[sel] = 1;
				if (i == cnt - 1) begin
					// cut of the phase, then fold the last vertex into the one before it
					keep = alive[prev];
					gone = alive[sel];
					if (attach[sel] < best)
						best = attach[sel];
					for (int k = 0; k < cnt; k++) begin
						o = alive[k];
						if (o != keep && o != gone) begin
							w = add_clip(merged_w[keep][o], merged_w[gone][o]);
							merged_w[keep][o] = w;
							merged_w[o][keep] = w;
						end
					end
					for (int k = sel; k + 1 < cnt; k++)
						alive[k] = alive[k + 1];
					break;
				end
				prev = sel;
				for (int j = 0; j < cnt; j++)
					if (!taken[j])
						attach[j] = add_clip(attach[j], merged_w[alive[sel]][alive[j]]);
			end
			cnt--;
		end
		return best;
	endfunction

	// Update the predictor for one accepted item; a typed value overrides the prediction.
	task automatic track_item(input gmc_pkg::cmd_t c, input logic [5:0] a,
		input logic [5:0] b, input logic [15:0] w, input bit typed,
		input logic [31:0] typed_cut);
		case (c)
			gmc_pkg::CMD_CLEAR: begin
				for (int i = 0; i < NV; i++)
					for (int j = 0; j < NV; j++)
						graph_w[i][j] = 0;
			end
			gmc_pkg::CMD_WRITE: begin
				graph_w[a][b] = {16'd0, w};
				graph_w[b][a] = {16'd0, w};
			end
			gmc_pkg::CMD_RUN: begin
				want = stoer_wagner_cut();
				cut_q.push_back(typed ? typed_cut : want);
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Driving tasks
	// ---------------------------------------------------------------
	task automatic send_item(input gmc_pkg::cmd_t c, input logic [5:0] a,
		input logic [5:0] b, input logic [15:0] w, input bit typed = 0,
		input logic [31:0] typed_cut = 0);
		if (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= c;
		node_a      <= a;
		node_b      <= b;
		edge_weight <= w;
		do @(posedge clk); while (!in_ready);
		track_item(c, a, b, w, typed, typed_cut);
	endtask

	// Let every expected item arrive, then allow for a trailing clear sweep.
	task automatic drain();
		in_valid <= 1'b0;
		while (cut_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_vertices(input logic [6:0] v);
		drain();
		cfg_valid    <= 1'b1;
		vertex_count <= v;
		do @(posedge clk); while (!cfg_ready);
		nv_set = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(7))
			0: return 16'hFFFF;
			1, 2: return 16'($urandom_range(0, 6));   // small values make ties
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Checking and watchdog
	// ---------------------------------------------------------------
	task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		fails++;
		if (fails <= 10)
			$display("mismatch %0d: %s expected %0d got %0d", fails, what, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (cut_q.size() == 0) begin
					flag_mismatch("unexpected min_cut item", 32'd0, min_cut);
				end else begin
					want = cut_q.pop_front();
					if (min_cut !== want)
						flag_mismatch("min_cut", want, min_cut);
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 31);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Directed table: a row either sets the vertex count or sends an item
	// ---------------------------------------------------------------
	typedef struct {
		bit            is_cfg;
		logic [6:0]    nv;
		gmc_pkg::cmd_t c;
		logic [5:0]    a;
		logic [5:0]    b;
		logic [15:0]   w;
		bit            typed;
		logic [31:0]   cut;
	} plan_row_t;

	plan_row_t plan [$];

	initial begin
		int nv, writes;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		vertex_count = '0;
		in_valid = 1'b0;
		command = gmc_pkg::CMD_NONE;
		node_a = '0;
		node_b = '0;
		edge_weight = '0;
		fails = 0;
		cycles = 0;
		calm = 0;
		nv_set = '0;
		for (int i = 0; i < NV; i++)
			for (int j = 0; j < NV; j++)
				graph_w[i][j] = 0;

		// no vertices, one vertex, two unconnected vertices: all cut to zero
		plan.push_back('{1, 7'd0, gmc_pkg::CMD_NONE, 0, 0, 0, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 1, 32'd0});
		plan.push_back('{1, 7'd1, gmc_pkg::CMD_NONE, 0, 0, 0, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 6'h3F, 6'h3F, 16'hFFFF, 1, 32'd0});
		plan.push_back('{1, 7'd2, gmc_pkg::CMD_NONE, 0, 0, 0, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 1, 32'd0});
		// heaviest edge, then a self loop which must not change the cut
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd0, 6'd1, 16'hFFFF, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 1, 32'd65535});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd1, 6'd1, 16'h1234, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 1, 32'd65535});
		// overwrite from the other side with zero
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd1, 6'd0, 16'h0000, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 1, 32'd0});
		// unused code: ignored
		plan.push_back('{0, 0, gmc_pkg::CMD_NONE, 6'h3F, 6'h3F, 16'hFFFF, 0, 0});
		// small ring with a chord; run twice, answer must repeat
		plan.push_back('{1, 7'd4, gmc_pkg::CMD_NONE, 0, 0, 0, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd0, 6'd1, 16'd5, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd1, 6'd2, 16'd5, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd2, 6'd3, 16'd1, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd3, 6'd0, 16'd5, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd0, 6'd2, 16'd7, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 0, 0});
		// top endpoints, alternating weight bits, outside the vertices in use
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd63, 6'd62, 16'hAAAA, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_WRITE, 6'd62, 6'd63, 16'h5555, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 0, 0});
		// clear wipes everything
		plan.push_back('{0, 0, gmc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0});
		plan.push_back('{0, 0, gmc_pkg::CMD_RUN, 0, 0, 0, 1, 32'd0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_vertices(plan[i].nv);
			else
				send_item(plan[i].c, plan[i].a, plan[i].b, plan[i].w,
					plan[i].typed, plan[i].cut);
		end

		// Random graphs: mostly well-formed edge sets over the live vertices, then one or two runs;
		// some noise on far endpoints and the unused code.
		for (int g = 0; g < RAND_GRAPHS; g++) begin
			calm = (g >= 10 && g < 15);
			case ($urandom_range(15))
				0: nv = $urandom_range(0, 1);
				1: nv = $urandom_range(9, 12);
				default: nv = $urandom_range(2, 8);
			endcase
			set_vertices(7'(nv));
			if ($urandom_range(3) == 0)
				send_item(gmc_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
			writes = $urandom_range(6, 14);
			for (int k = 0; k < writes; k++) begin
				case ($urandom_range(19))
					0: send_item(gmc_pkg::CMD_NONE, 6'($urandom), 6'($urandom),
						16'($urandom));
					1, 2: send_item(gmc_pkg::CMD_WRITE, 6'($urandom), 6'($urandom),
						pick_weight());
					default: send_item(gmc_pkg::CMD_WRITE,
						6'($urandom_range(0, (nv > 1) ? nv - 1 : 1)),
						6'($urandom_range(0, (nv > 1) ? nv - 1 : 1)), pick_weight());
				endcase
			end
			send_item(gmc_pkg::CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
			if ($urandom_range(2) == 0)
				send_item(gmc_pkg::CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		end
		calm = 0;

		// One full-size graph; the count above the maximum folds down to it.
		set_vertices(7'd127);
		for (int k = 0; k < 40; k++)
			send_item(gmc_pkg::CMD_WRITE, 6'($urandom), 6'($urandom), pick_weight());
		send_item(gmc_pkg::CMD_RUN, 0, 0, 0);

		drain();
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/gmc_pkg.sv
design/gmc_ram.sv
design/gmc_cell.sv
design/global_min_cut_dense.sv
test/global_min_cut_dense_tb.sv
